// File: hdl/apab_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the ARGB pixel blend block.
package apab_pkg;

    localparam int CH_W     = 8;   // one color channel or alpha
    localparam int PITCH_W  = 9;   // row pitch register
    localparam int RAW_W    = 17;  // pitch * y + x before wrapping
    localparam int RECIP_W  = 10;  // reciprocal of the store depth
    localparam int QUO_W    = 10;  // row count estimate for the wrap
    localparam int NUM_W    = 17;  // blend numerator per channel
    localparam int LANES    = 3;   // blue, green, red
    localparam int DIV_CNT_W = 2;  // two quotient bits per cycle

    localparam logic [PITCH_W-1:0] PITCH_RST  = 9'd256;
    localparam logic [CH_W-1:0]    ALPHA_NONE = 8'h00;
    localparam logic [CH_W-1:0]    ALPHA_FULL = 8'hff;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_QUO   = 10'b00_0000_0100,
        S_PROD  = 10'b00_0000_1000,
        S_REM   = 10'b00_0001_0000,
        S_READ  = 10'b00_0010_0000,
        S_MIX   = 10'b00_0100_0000,
        S_NUM   = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_WB    = 10'b10_0000_0000
    } state_t;

    // floor(x / 255), exact for every 8x8 product
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W:0] sum;
        sum = {1'b0, x} + {9'd0, x[2*CH_W-1:CH_W]} + 17'd1;
        return sum[2*CH_W-1:CH_W];
    endfunction

endpackage

// File: hdl/argb_pixel_alpha_blend.sv
`timescale 1ns / 1ps
// Top level: source-over blend of one ARGB8888 pixel into an on-chip frame store.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+----------------------
//  request   | pos_x, pos_y, src_color, global_alpha         | start, taken if !busy
//  result    | pixel_out, was_written                        | done, one-cycle strobe
//  config    | row_pitch                                     | cfg_valid / cfg_ready
//
// After reset the store is swept to zero, one word a cycle, with busy high.
// A request whose effective alpha is 0 or 255 returns done from S_MIX; a blended request
// goes on to S_NUM, S_DIV and S_WB. S_QUO, S_PROD and S_REM wrap the address into the store,
// S_READ reads it, and the per-channel divide by the output alpha retires two quotient bits a cycle.
// One request is in flight at a time; busy stays high until done. done cannot be held off.
module argb_pixel_alpha_blend
    import apab_pkg::*;
#(
    parameter int FRAME_WORDS = 65536
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          pos_x,
    input  logic [7:0]          pos_y,
    input  logic [31:0]         src_color,
    input  logic [7:0]          global_alpha,
    output logic                done,
    output logic [31:0]         pixel_out,
    output logic                was_written,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PITCH_W-1:0]  row_pitch
);

    localparam int AW      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int FW_BITS = $clog2(FRAME_WORDS + 1);
    localparam int CW      = (RAW_W > FW_BITS) ? RAW_W : FW_BITS;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((2 ** RAW_W) / FRAME_WORDS);
    localparam logic [FW_BITS-1:0] FW_C    = FW_BITS'(FRAME_WORDS);
    localparam logic [CW-1:0]      FW_CMP  = CW'(FRAME_WORDS);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(FRAME_WORDS - 1);

    logic [31:0] mem [0:FRAME_WORDS-1];

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   done_reg, done_next;
    logic                   written_reg, written_next;
    logic [PITCH_W-1:0]     pitch_reg, pitch_next;

    logic [RAW_W-1:0]       raw_reg, raw_next;
    logic [CH_W-1:0]        fa_reg, fa_next;
    logic [31:0]            src_reg, src_next;
    logic [QUO_W-1:0]       q_reg, q_next;
    logic [RAW_W-1:0]       qd_reg, qd_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [CH_W-1:0]        comb_reg, comb_next;
    logic [CH_W-1:0]        oa_reg, oa_next;
    logic [NUM_W-1:0]       rem_reg [LANES], rem_next [LANES];
    logic [CH_W-1:0]        quo_reg [LANES], quo_next [LANES];
    logic [31:0]            pix_reg, pix_next;
    logic [31:0]            rd_data_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [31:0]            mem_wdata;

    logic [RAW_W-1:0]       pitch_prod;
    logic [2*CH_W-1:0]      alpha_prod;
    logic [RAW_W+RECIP_W-1:0] recip_prod;
    logic [QUO_W+FW_BITS-1:0] qd_full;
    logic [CW-1:0]          wrap_rem;
    logic [CH_W-1:0]        bg_alpha;
    logic [CH_W-1:0]        ba_left;
    logic [NUM_W-1:0]       rem_step [LANES];
    logic [CH_W-1:0]        quo_step [LANES];

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done        = done_reg;
    assign was_written = written_reg;
    assign pixel_out   = pix_reg;

    assign bg_alpha = rd_data_reg[31:24];
    assign ba_left  = bg_alpha - comb_reg;

    // Restoring divide, two quotient bits per lane per cycle
    always_comb
    begin
        logic [2:0]       bit_hi;
        logic [2:0]       bit_lo;
        logic [NUM_W-1:0] d_hi;
        logic [NUM_W-1:0] d_lo;
        logic [NUM_W-1:0] r;
        logic [CH_W-1:0]  q;
        bit_hi = {div_cnt_reg, 1'b1};
        bit_lo = {div_cnt_reg, 1'b0};
        d_hi = NUM_W'(oa_reg) << bit_hi;
        d_lo = NUM_W'(oa_reg) << bit_lo;
        for (int i = 0; i < LANES; i++)
        begin
            r = rem_reg[i];
            q = quo_reg[i];
            if (r >= d_hi)
            begin
                r = r - d_hi;
                q[bit_hi] = 1'b1;
            end
            if (r >= d_lo)
            begin
                r = r - d_lo;
                q[bit_lo] = 1'b1;
            end
            rem_step[i] = r;
            quo_step[i] = q;
        end
    end

    always_comb
    begin
        logic [2*CH_W-1:0] fg_term;
        logic [2*CH_W-1:0] bg_term;
        fg_term      = '0;
        bg_term      = '0;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        div_cnt_next = div_cnt_reg;
        done_next    = 1'b0;
        written_next = written_reg;
        pitch_next   = pitch_reg;
        raw_next     = raw_reg;
        fa_next      = fa_reg;
        src_next     = src_reg;
        q_next       = q_reg;
        qd_next      = qd_reg;
        addr_next    = addr_reg;
        comb_next    = comb_reg;
        oa_next      = oa_reg;
        pix_next     = pix_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = src_reg;

        pitch_prod = pitch_reg * pos_y;
        alpha_prod = src_color[31:24] * global_alpha;
        recip_prod = raw_reg * RECIP_C;
        qd_full    = q_reg * FW_C;
        wrap_rem   = CW'(raw_reg - qd_reg);
        if (wrap_rem >= FW_CMP)
        begin
            wrap_rem = wrap_rem - FW_CMP;
        end

        if (cfg_valid && cfg_ready)
        begin
            pitch_next = row_pitch;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = 32'd0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    raw_next   = pitch_prod + RAW_W'(pos_x);
                    fa_next    = div255(alpha_prod);
                    src_next   = src_color;
                    state_next = S_QUO;
                end
            end
            S_QUO:
            begin
                // row estimate, never above the true quotient and at most one below
                q_next     = recip_prod[RAW_W+RECIP_W-1:RAW_W];
                state_next = S_PROD;
            end
            S_PROD:
            begin
                qd_next    = qd_full[RAW_W-1:0];
                state_next = S_REM;
            end
            S_REM:
            begin
                addr_next  = wrap_rem[AW-1:0];
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (fa_reg == ALPHA_NONE)
                begin
                    pix_next     = rd_data_reg;
                    written_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (fa_reg == ALPHA_FULL)
                begin
                    mem_we       = 1'b1;
                    pix_next     = src_reg;
                    written_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    comb_next  = div255(fa_reg * bg_alpha);
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                oa_next = fa_reg + ba_left;
                for (int i = 0; i < LANES; i++)
                begin
                    fg_term = src_reg[CH_W*i +: CH_W] * fa_reg;
                    bg_term = rd_data_reg[CH_W*i +: CH_W] * ba_left;
                    rem_next[i] = NUM_W'(fg_term) + NUM_W'(bg_term);
                    quo_next[i] = '0;
                end
                div_cnt_next = '1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_we       = 1'b1;
                mem_wdata    = {oa_reg, quo_reg[2], quo_reg[1], quo_reg[0]};
                pix_next     = mem_wdata;
                written_next = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
            written_reg <= 1'b0;
            pitch_reg   <= PITCH_RST;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            div_cnt_reg <= div_cnt_next;
            done_reg    <= done_next;
            written_reg <= written_next;
            pitch_reg   <= pitch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        fa_reg   <= fa_next;
        src_reg  <= src_next;
        q_reg    <= q_next;
        qd_reg   <= qd_next;
        addr_reg <= addr_next;
        comb_reg <= comb_next;
        oa_reg   <= oa_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        pix_reg  <= pix_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

`ifndef SYNTH
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_MIX || $past(state_reg) == S_WB))
        else $error("done without a finishing state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_QUO))
        else $error("accepted request did not start address wrap");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (oa_reg != 8'd0))
        else $error("divide by zero output alpha");

    a_skip_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !written_reg) |-> ($past(fa_reg) == ALPHA_NONE))
        else $error("store skipped with nonzero alpha");
`endif

endmodule

// File: tb/sv/argb_pixel_alpha_blend_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ARGB8888 source-over pixel blend block.
module argb_pixel_alpha_blend_tb
    import apab_pkg::*;
();

    localparam int FRAME_WORDS = 65536;
    // the post-reset clear sweep runs through the whole store with nothing accepted
    localparam int IDLE_LIMIT  = 4 * FRAME_WORDS;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] color;
        logic [7:0]  galpha;
    } pixel_req_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        written;
    } blend_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         pos_x = '0;
    logic [7:0]         pos_y = '0;
    logic [31:0]        src_color = '0;
    logic [7:0]         global_alpha = '0;
    logic               done;
    logic [31:0]        pixel_out;
    logic               was_written;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [PITCH_W-1:0] row_pitch = PITCH_RST;

    // shadow of the block's frame store and pitch register
    logic [31:0]        frame_model [0:FRAME_WORDS-1];
    logic [PITCH_W-1:0] pitch_model = PITCH_RST;

    pixel_req_t         pixel_requests [$];
    blend_result_t      expected_pixels [$];

    logic               pitch_write_pending = 1'b0;
    logic [PITCH_W-1:0] pitch_write_value = '0;
    int                 gap_left = 0;
    int                 burst_left = 0;
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    argb_pixel_alpha_blend #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .src_color    (src_color),
        .global_alpha (global_alpha),
        .done         (done),
        .pixel_out    (pixel_out),
        .was_written  (was_written),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .row_pitch    (row_pitch)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow store and return the word the block must report.
    function automatic blend_result_t blend_into_frame(input logic [7:0] x,
                                                       input logic [7:0] y,
                                                       input logic [31:0] color,
                                                       input logic [7:0] galpha);
        int unsigned   addr;
        int unsigned   fa;
        int unsigned   ba;
        int unsigned   comb;
        int unsigned   oa;
        int unsigned   num;
        logic [31:0]   bg;
        logic [7:0]    mixed [0:2];
        blend_result_t res;
        addr = (int'(pitch_model) * int'(y) + int'(x)) % FRAME_WORDS;
        fa = (int'(color[31:24]) * int'(galpha)) / 255;
        res.written = 1'b0;
        if (fa == int'(ALPHA_FULL))
        begin
            frame_model[addr] = color;
            res.written = 1'b1;
        end
        else if (fa != int'(ALPHA_NONE))
        begin
            bg   = frame_model[addr];
            ba   = int'(bg[31:24]);
            comb = (fa * ba) / 255;
            oa   = fa + ba - comb;
            for (int i = 0; i < 3; i++)
            begin
                num = int'(color[8*i +: 8]) * fa + int'(bg[8*i +: 8]) * ba
                      - int'(bg[8*i +: 8]) * comb;
                mixed[i] = 8'(num / oa);
            end
            frame_model[addr] = {8'(oa), mixed[2], mixed[1], mixed[0]};
            res.written = 1'b1;
        end
        res.pixel = frame_model[addr];
        return res;
    endfunction

    // Mostly back-to-back or short gaps, a few long ones, and now and then a gapless burst.
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive requests and pitch writes; predict at the edge where each request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            pos_x        <= '0;
            pos_y        <= '0;
            src_color    <= '0;
            global_alpha <= '0;
            cfg_valid    <= 1'b0;
            row_pitch    <= PITCH_RST;
        end
        else
        begin
            if (start && !busy)
                expected_pixels.push_back(blend_into_frame(pos_x, pos_y, src_color,
                                                           global_alpha));

            if (cfg_valid && cfg_ready)
            begin
                pitch_model = row_pitch;
                cfg_valid  <= 1'b0;
            end
            else if (pitch_write_pending)
            begin
                row_pitch  <= pitch_write_value;
                cfg_valid  <= 1'b1;
                pitch_write_pending = 1'b0;
            end

            if (start && busy)
            begin
                // hold the request until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pixel_requests.size() > 0)
            begin
                pixel_req_t req;
                req = pixel_requests.pop_front();
                pos_x        <= req.x;
                pos_y        <= req.y;
                src_color    <= req.color;
                global_alpha <= req.galpha;
                start        <= 1'b1;
                gap_left = pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_out %h was_written %b", pixel_out, was_written);
                mismatches++;
            end
            else
            begin
                blend_result_t exp_res;
                exp_res = expected_pixels.pop_front();
                if (pixel_out !== exp_res.pixel)
                begin
                    $error("pixel_out mismatch: expected %h, actual %h", exp_res.pixel, pixel_out);
                    mismatches++;
                end
                if (was_written !== exp_res.written)
                begin
                    $error("was_written mismatch: expected %b, actual %b",
                           exp_res.written, was_written);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_pixel(input logic [7:0] x, input logic [7:0] y,
                             input logic [31:0] color, input logic [7:0] galpha);
        pixel_requests.push_back('{x, y, color, galpha});
    endtask

    // Random request: mostly a small cluster of addresses so blends land on painted pixels.
    task automatic add_random_pixel();
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] color;
        logic [7:0]  galpha;
        int          r;
        if ($urandom_range(0, 99) < 65)
        begin
            x = 8'($urandom_range(0, 7));
            y = 8'($urandom_range(0, 3));
        end
        else
        begin
            x = 8'($urandom);
            y = 8'($urandom);
        end
        color = $urandom;
        r = $urandom_range(0, 9);
        if (r < 2)
            color[31:24] = ALPHA_FULL;
        else if (r == 2)
            color[31:24] = ALPHA_NONE;
        else if (r == 3)
            color[31:24] = 8'($urandom_range(1, 3));
        r = $urandom_range(0, 9);
        if (r < 5)
            galpha = ALPHA_FULL;
        else if (r == 5)
            galpha = ALPHA_NONE;
        else
            galpha = 8'($urandom);
        add_pixel(x, y, color, galpha);
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pixel_requests.size() != 0 || start || expected_pixels.size() != 0);
    endtask

    task automatic write_pitch(input logic [PITCH_W-1:0] pitch);
        @(negedge clk);
        pitch_write_value   = pitch;
        pitch_write_pending = 1'b1;
        do
            @(negedge clk);
        while (pitch_write_pending || cfg_valid);
    endtask

    task automatic run_phase(input logic [PITCH_W-1:0] pitch, input int n_random);
        wait_quiet();
        write_pitch(pitch);
        @(negedge clk);
        // corners of the coordinate range, opaque then blended over
        add_pixel(8'hff, 8'hff, {ALPHA_FULL, 24'($urandom)}, ALPHA_FULL);
        add_pixel(8'hff, 8'hff, $urandom, 8'h90);
        add_pixel(8'h00, 8'h00, $urandom, 8'($urandom));
        add_pixel(8'h00, 8'hff, $urandom, ALPHA_FULL);
        for (int i = 0; i < n_random; i++)
            add_random_pixel();
    endtask

    initial
    begin
        foreach (frame_model[i])
            frame_model[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait_quiet();
        write_pitch(PITCH_RST);
        @(negedge clk);
        add_pixel(8'd0, 8'd0, 32'hff112233, ALPHA_FULL);     // opaque store
        add_pixel(8'd0, 8'd0, 32'hff445566, ALPHA_NONE);     // zero global alpha
        add_pixel(8'd0, 8'd0, 32'h00778899, ALPHA_FULL);     // transparent source
        add_pixel(8'd0, 8'd0, 32'h80ff0000, ALPHA_FULL);     // half over opaque
        add_pixel(8'd1, 8'd0, 32'h80abcdef, ALPHA_FULL);     // blend onto cleared word
        add_pixel(8'd2, 8'd0, 32'h01ffffff, ALPHA_FULL);     // smallest effective alpha
        add_pixel(8'd2, 8'd0, 32'hff0000ff, 8'd1);           // source opaque, global tiny
        add_pixel(8'd2, 8'd0, 32'h02ffffff, 8'd128);         // product just over 255
        add_pixel(8'd3, 8'd0, 32'hffffffff, 8'd254);         // effective alpha 254
        add_pixel(8'd3, 8'd0, 32'h7f000000, ALPHA_FULL);
        add_pixel(8'd3, 8'd0, 32'h7f000000, ALPHA_FULL);
        add_pixel(8'd4, 8'd0, 32'hffffffff, ALPHA_FULL);
        add_pixel(8'd4, 8'd0, 32'h7f000000, ALPHA_FULL);     // dark over white
        add_pixel(8'd4, 8'd0, 32'h00000000, ALPHA_FULL);
        add_pixel(8'd255, 8'd255, 32'hffffffff, ALPHA_FULL); // last word of the store
        add_pixel(8'd255, 8'd255, 32'hfe000000, ALPHA_FULL);
        add_pixel(8'd255, 8'd0, 32'h40a5a5a5, 8'd200);
        add_pixel(8'd0, 8'd1, 32'hc05a5a5a, 8'd100);
        add_pixel(8'd0, 8'd1, 32'hff000000, 8'd255);

        run_phase(PITCH_RST, 115);
        run_phase(9'd1, 115);
        run_phase(9'd0, 115);
        run_phase(9'd511, 115);     // address wraps past the end of the store
        run_phase(9'($urandom_range(2, 510)), 115);
        run_phase(9'($urandom_range(2, 510)), 115);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
